// ===== sv/rasc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rasc_pkg;

   localparam int STACK_DEPTH   = 1024;
   localparam int ADDRESS_WIDTH = 32;

   localparam int KIND_WIDTH    = 3;
   localparam int DATA_WIDTH    = 32;
   localparam int LEVEL_WIDTH   = 11;
   localparam int ERROR_WIDTH   = 2;

   // top pointer holds 0..STACK_DEPTH, memory index 0..STACK_DEPTH-1
   localparam int PTR_WIDTH     = $clog2(STACK_DEPTH + 1);
   localparam int IDX_WIDTH     = $clog2(STACK_DEPTH);
   localparam int CMP_WIDTH     = (PTR_WIDTH > LEVEL_WIDTH) ? PTR_WIDTH : LEVEL_WIDTH;

   typedef enum logic [KIND_WIDTH-1:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_DROP  = 3'd2,
      OP_PEEK  = 3'd3,
      OP_CLEAR = 3'd4
   } rasc_op_type;

   typedef enum logic [ERROR_WIDTH-1:0] {
      ERR_NONE  = 2'd0,
      ERR_UNDER = 2'd1,
      ERR_OVER  = 2'd2
   } rasc_err_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] depth;
      rasc_err_type           err;
      logic                   rd_used;
   } rasc_meta_type;

   typedef struct packed {
      logic                     wr_en;
      logic [IDX_WIDTH-1:0]     wr_addr;
      logic [ADDRESS_WIDTH-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_WIDTH-1:0]     rd_addr;
   } rasc_mem_req_type;

endpackage

`default_nettype wire

// ===== sv/rasc_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rasc_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/rasc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rasc_ctrl
   import rasc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [KIND_WIDTH-1:0]    kind,
   input  wire logic [DATA_WIDTH-1:0]    push_address,
   input  wire logic [LEVEL_WIDTH-1:0]   level_count,
   output rasc_mem_req_type              mem_req,
   output rasc_meta_type                 meta
);

   logic [PTR_WIDTH-1:0] top_ff;
   logic [PTR_WIDTH-1:0] top_in;
   logic [CMP_WIDTH-1:0] top_ext;
   logic [CMP_WIDTH-1:0] count_ext;
   logic [CMP_WIDTH-1:0] peek_idx;
   rasc_err_type         err;
   logic                 wr_en;
   logic                 rd_en;
   logic [IDX_WIDTH-1:0] rd_addr;

   assign top_ext   = CMP_WIDTH'(top_ff);
   assign count_ext = CMP_WIDTH'(level_count);
   assign peek_idx  = top_ext - count_ext;

   always_comb begin
      top_in  = top_ff;
      err     = ERR_NONE;
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      rd_addr = IDX_WIDTH'(top_ff - PTR_WIDTH'(1));
      case (rasc_op_type'(kind))
         OP_PUSH: begin
            if (top_ff == PTR_WIDTH'(STACK_DEPTH)) begin
               err = ERR_OVER;
            end else begin
               wr_en  = 1'b1;
               top_in = top_ff + PTR_WIDTH'(1);
            end
         end
         OP_POP: begin
            if (top_ff == '0) begin
               err = ERR_UNDER;
            end else begin
               rd_en  = 1'b1;
               top_in = top_ff - PTR_WIDTH'(1);
            end
         end
         OP_DROP: begin
            if (count_ext > top_ext) begin
               err = ERR_UNDER;
            end else begin
               top_in = PTR_WIDTH'(top_ext - count_ext);
            end
         end
         OP_PEEK: begin
            if (count_ext != '0 && count_ext <= top_ext) begin
               rd_en   = 1'b1;
               rd_addr = IDX_WIDTH'(peek_idx);
            end
         end
         OP_CLEAR: begin
            top_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else if (accept) begin
         top_ff <= top_in;
      end
   end

   assign mem_req.wr_en   = accept & wr_en;
   assign mem_req.wr_addr = IDX_WIDTH'(top_ff);
   assign mem_req.wr_data = ADDRESS_WIDTH'(push_address);
   assign mem_req.rd_en   = accept & rd_en;
   assign mem_req.rd_addr = rd_addr;

   assign meta.depth   = LEVEL_WIDTH'(top_in);
   assign meta.err     = err;
   assign meta.rd_used = rd_en;

endmodule

`default_nettype wire

// ===== sv/return_address_stack_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Return address stack: a LIFO of STACK_DEPTH addresses held in one synchronous
// RAM. Each request transaction is one operation (push, pop, drop, peek, clear)
// and yields exactly one response transaction with read data, depth after the
// operation and an error code. A request is taken every cycle unless responses
// stall; its response passes through the RAM read register and the output
// register, and one more request is still taken while a response waits.
// The depth pointer is updated at acceptance, so back-to-back operations on
// the same entry need no interlock. RAM contents are not cleared at reset.

module return_address_stack_core
   import rasc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [KIND_WIDTH-1:0]  req_kind,
   input  wire logic [DATA_WIDTH-1:0]  req_push_address,
   input  wire logic [LEVEL_WIDTH-1:0] req_level_count,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [DATA_WIDTH-1:0]  rsp_read_address,
   output logic      [LEVEL_WIDTH-1:0] rsp_stack_depth,
   output logic      [ERROR_WIDTH-1:0] rsp_error_code
);

   logic                     accept;
   logic                     s1_advance;
   rasc_mem_req_type         mem_req;
   rasc_meta_type            meta;
   logic [ADDRESS_WIDTH-1:0] rd_data;

   logic                     s1_valid_ff;
   rasc_meta_type            s1_meta_ff;
   logic                     out_valid_ff;
   logic [DATA_WIDTH-1:0]    out_addr_ff;
   rasc_meta_type            out_meta_ff;

   assign s1_advance = s1_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready  = ~s1_valid_ff | s1_advance;
   assign accept     = req_valid & req_ready;

   rasc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_kind),
      .push_address (req_push_address),
      .level_count  (req_level_count),
      .mem_req      (mem_req),
      .meta         (meta)
   );

   rasc_mem #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (ADDRESS_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_meta_ff <= s1_meta_ff;
         out_addr_ff <= s1_meta_ff.rd_used ? DATA_WIDTH'(rd_data) : '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_address = out_addr_ff;
   assign rsp_stack_depth  = out_meta_ff.depth;
   assign rsp_error_code   = out_meta_ff.err;

   a_over_only_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_OVER |-> rsp_stack_depth == LEVEL_WIDTH'(STACK_DEPTH))
      else $error("overflow reported below full depth");

   a_read_no_error: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_meta_ff.rd_used |-> s1_meta_ff.err == ERR_NONE)
      else $error("RAM read on a refused operation");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == OP_CLEAR |=> s1_valid_ff && s1_meta_ff.depth == '0)
      else $error("clear did not empty the stack");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_meta_ff.rd_used |=> rsp_valid && rsp_read_address == '0)
      else $error("nonzero read data without a read");

endmodule

`default_nettype wire
